### design/wdh_pkg.sv
// Package for the word dictionary hash probe: sizes, widths, codes, states.
// No dependencies; every other design file imports it.
`timescale 1ns / 1ps

package wdh_pkg;

    localparam int SLOTS     = 10;
    localparam int MAX_CHARS = 29;

    localparam int CMD_W   = 2;
    localparam int CHR_W   = 8;
    localparam int STAT_W  = 3;
    localparam int SLOTO_W = 4;

    localparam int SLOT_W = $clog2(SLOTS);
    localparam int NCNT_W = $clog2(SLOTS + 1);
    localparam int LEN_W  = $clog2(MAX_CHARS + 1);
    localparam int IDX_W  = (MAX_CHARS > 1) ? $clog2(MAX_CHARS) : 1;
    localparam int MEM_D  = SLOTS * MAX_CHARS;
    localparam int BASE_W = $clog2(MEM_D);
    localparam int SUM_W  = $clog2(MAX_CHARS * 255 + 1);
    localparam int DCNT_W = $clog2(SUM_W);

    // reciprocal of SLOTS, exact for every SUM_W-bit quotient
    localparam int HASH_SHIFT = SUM_W + SLOT_W;
    localparam int HASH_RECIP = (2 ** HASH_SHIFT + SLOTS - 1) / SLOTS;
    localparam int RCP_W      = $clog2(HASH_RECIP + 1);

    localparam logic [CMD_W-1:0] CMD_INSERT = 2'd0;
    localparam logic [CMD_W-1:0] CMD_FIND   = 2'd1;
    localparam logic [CMD_W-1:0] CMD_REMOVE = 2'd2;
    localparam logic [CMD_W-1:0] CMD_NONE   = 2'd3;

    typedef enum logic [STAT_W-1:0] {
        ST_STORED  = 3'd0,
        ST_FULL    = 3'd1,
        ST_FOUND   = 3'd2,
        ST_MISS    = 3'd3,
        ST_REMOVED = 3'd4,
        ST_BADKEY  = 3'd5
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_DIVQ,
        S_DIVM,
        S_PROBE,
        S_KCMP_RD,
        S_KCMP_CHK,
        S_CP_RD,
        S_CP_WR,
        S_FIND_RD,
        S_FIND_EMIT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic busy;
        logic done;
    } div_stat_t;

endpackage

### design/wdh_if.sv
// Handshake channels for commands in and results out.
// Depends on wdh_pkg for field widths.
`timescale 1ns / 1ps

interface wdh_in_if import wdh_pkg::*; ();
    logic             valid;
    logic             ready;
    logic [CMD_W-1:0] command;
    logic             part;
    logic [CHR_W-1:0] char_code;
    logic             last_char;

    modport source (output valid, command, part, char_code, last_char, input ready);
    modport sink (input valid, command, part, char_code, last_char, output ready);
endinterface

interface wdh_out_if import wdh_pkg::*; ();
    logic               valid;
    logic               ready;
    logic [STAT_W-1:0]  status;
    logic [SLOTO_W-1:0] slot;
    logic [CHR_W-1:0]   meaning_char;
    logic               last;

    modport source (output valid, status, slot, meaning_char, last, input ready);
    modport sink (input valid, status, slot, meaning_char, last, output ready);
endinterface

### design/wdh_div.sv
// Restoring divider, one quotient bit per cycle; divides the key sum by the key length.
// Depends on wdh_pkg.
`timescale 1ns / 1ps

module wdh_div import wdh_pkg::*; (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [SUM_W-1:0] dividend,
    input  logic [SUM_W-1:0] divisor,
    output logic [SUM_W-1:0] quotient,
    output div_stat_t        stat
);

    logic [SUM_W-1:0]  rem_reg, rem_next;
    logic [SUM_W-1:0]  quot_reg, quot_next;
    logic [SUM_W-1:0]  dvs_reg, dvs_next;
    logic [DCNT_W-1:0] cnt_reg, cnt_next;
    logic              busy_reg, busy_next;
    logic              done_reg, done_next;
    logic [SUM_W:0]    trial;
    logic [SUM_W:0]    diff;

    always_comb
    begin
        trial     = {rem_reg, quot_reg[SUM_W-1]};
        diff      = trial - {1'b0, dvs_reg};
        rem_next  = rem_reg;
        quot_next = quot_reg;
        dvs_next  = dvs_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        if (start)
        begin
            rem_next  = '0;
            quot_next = dividend;
            dvs_next  = divisor;
            cnt_next  = '0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (trial >= {1'b0, dvs_reg})
            begin
                rem_next  = diff[SUM_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b1};
            end
            else
            begin
                rem_next  = trial[SUM_W-1:0];
                quot_next = {quot_reg[SUM_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + DCNT_W'(1);
            if (cnt_reg == DCNT_W'(SUM_W - 1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        quot_reg <= quot_next;
        dvs_reg  <= dvs_next;
    end

    assign quotient  = quot_reg;
    assign stat      = '{busy: busy_reg, done: done_reg};

endmodule

### design/word_dictionary_hash_probe.sv
// Word dictionary with linear probing; key and meaning stream in one character per transfer.
// A character not ending a command is buffered; intake stays ready. A command end starts the
// 13-step division, then a wrap step mod SLOTS gives the home slot. Visited slots are probed,
// compared key characters read and checked; insert copies MAX_CHARS characters, find reads
// and emits each meaning character. Intake stalls until the last result loads. Reset empties
// the slot table at once; no clearing pass. Depends on wdh_pkg, wdh_if, wdh_div.
`timescale 1ns / 1ps

module word_dictionary_hash_probe import wdh_pkg::*; (
    input logic      clk,
    input logic      rst_n,
    wdh_in_if.sink   req,
    wdh_out_if.source rsp
);

    state_t             state_reg, state_next;
    logic [LEN_W-1:0]   klen_reg, klen_next;
    logic [SUM_W-1:0]   sum_reg, sum_next;
    logic [LEN_W-1:0]   mlen_reg, mlen_next;
    logic               ovf_reg, ovf_next;
    logic               kdone_reg, kdone_next;
    logic [CMD_W-1:0]   cmd_reg, cmd_next;
    logic [SLOT_W-1:0]  s_reg, s_next;
    logic [NCNT_W-1:0]  n_reg, n_next;
    logic [BASE_W-1:0]  base_reg, base_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic [SUM_W-1:0]   hq_reg, hq_next;
    status_t            res_status_reg, res_status_next;
    logic [SLOTO_W-1:0] res_slot_reg, res_slot_next;
    logic [SLOTS-1:0]   used_reg, used_next;

    logic               out_valid_reg, out_valid_next;
    logic [STAT_W-1:0]  out_status_reg, out_status_next;
    logic [SLOTO_W-1:0] out_slot_reg, out_slot_next;
    logic [CHR_W-1:0]   out_char_reg, out_char_next;
    logic               out_last_reg, out_last_next;

    logic [CHR_W-1:0] key_mem [MEM_D];
    logic [CHR_W-1:0] mean_mem [MEM_D];
    logic [CHR_W-1:0] ik_mem [MAX_CHARS];
    logic [CHR_W-1:0] im_mem [MAX_CHARS];
    logic [LEN_W-1:0] slot_klen_reg [SLOTS];
    logic [LEN_W-1:0] slot_mlen_reg [SLOTS];
    logic [CHR_W-1:0] key_rd_reg, mean_rd_reg, ik_rd_reg, im_rd_reg;

    logic             ik_we, im_we, rd_en, st_we, slen_we;
    logic [IDX_W-1:0] in_addr;
    logic [BASE_W-1:0] mem_addr;
    logic             div_start;
    logic [SUM_W-1:0] div_a, div_b, div_q;
    div_stat_t        div_stat;
    logic [SUM_W+RCP_W-1:0] recip_prod;
    logic [SUM_W-1:0] wrap_val;
    logic             out_free;
    logic [LEN_W-1:0] eff_klen, eff_mlen;
    logic [SUM_W-1:0] eff_sum;
    logic             eff_ovf;
    logic             advance;
    logic [SLOT_W-1:0] home;
    logic [LEN_W-1:0] idx_ext;

    wdh_div u_div (
        .clk       (clk),
        .rst_n     (rst_n),
        .start     (div_start),
        .dividend  (div_a),
        .divisor   (div_b),
        .quotient  (div_q),
        .stat      (div_stat)
    );

    assign req.ready        = (state_reg == S_IDLE);
    assign rsp.valid        = out_valid_reg;
    assign rsp.status       = out_status_reg;
    assign rsp.slot         = out_slot_reg;
    assign rsp.meaning_char = out_char_reg;
    assign rsp.last         = out_last_reg;

    assign out_free   = !out_valid_reg || rsp.ready;
    assign mem_addr   = base_reg + BASE_W'(idx_reg);
    assign recip_prod = (SUM_W + RCP_W)'(div_q) * (SUM_W + RCP_W)'(HASH_RECIP);
    assign wrap_val   = div_q - hq_reg * SUM_W'(SLOTS);
    assign home       = wrap_val[SLOT_W-1:0];
    assign idx_ext    = LEN_W'(idx_reg);

    always_comb
    begin
        state_next      = state_reg;
        klen_next       = klen_reg;
        sum_next        = sum_reg;
        mlen_next       = mlen_reg;
        ovf_next        = ovf_reg;
        kdone_next      = kdone_reg;
        cmd_next        = cmd_reg;
        s_next          = s_reg;
        n_next          = n_reg;
        base_next       = base_reg;
        idx_next        = idx_reg;
        hq_next         = hq_reg;
        res_status_next = res_status_reg;
        res_slot_next   = res_slot_reg;
        used_next       = used_reg;
        out_valid_next  = out_valid_reg && !rsp.ready;
        out_status_next = out_status_reg;
        out_slot_next   = out_slot_reg;
        out_char_next   = out_char_reg;
        out_last_next   = out_last_reg;
        ik_we           = 1'b0;
        im_we           = 1'b0;
        in_addr         = '0;
        rd_en           = 1'b0;
        st_we           = 1'b0;
        slen_we         = 1'b0;
        div_start       = 1'b0;
        div_a           = sum_reg;
        div_b           = SUM_W'(klen_reg);
        advance         = 1'b0;
        eff_klen        = kdone_reg ? '0 : klen_reg;
        eff_mlen        = kdone_reg ? '0 : mlen_reg;
        eff_sum         = kdone_reg ? '0 : sum_reg;
        eff_ovf         = kdone_reg ? 1'b0 : ovf_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (req.valid)
                begin
                    cmd_next = req.command;
                    if (!req.part)
                    begin
                        klen_next = eff_klen;
                        sum_next  = eff_sum;
                        mlen_next = eff_mlen;
                        ovf_next  = eff_ovf;
                        if (eff_klen < LEN_W'(MAX_CHARS))
                        begin
                            ik_we     = 1'b1;
                            in_addr   = eff_klen[IDX_W-1:0];
                            klen_next = eff_klen + LEN_W'(1);
                            sum_next  = eff_sum + SUM_W'(req.char_code);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        kdone_next = 1'b0;
                        if (req.last_char)
                        begin
                            kdone_next = 1'b1;
                            if (req.command == CMD_NONE)
                            begin
                                klen_next  = '0;
                                sum_next   = '0;
                                mlen_next  = '0;
                                ovf_next   = 1'b0;
                                kdone_next = 1'b0;
                            end
                            else if (req.command != CMD_INSERT)
                            begin
                                if (ovf_next)
                                begin
                                    res_status_next = ST_BADKEY;
                                    res_slot_next   = '0;
                                    state_next      = S_EMIT;
                                end
                                else
                                begin
                                    div_start  = 1'b1;
                                    div_a      = sum_next;
                                    div_b      = SUM_W'(klen_next);
                                    state_next = S_DIVQ;
                                end
                            end
                        end
                    end
                    else if (req.command == CMD_INSERT)
                    begin
                        if (mlen_reg < LEN_W'(MAX_CHARS))
                        begin
                            im_we     = 1'b1;
                            in_addr   = mlen_reg[IDX_W-1:0];
                            mlen_next = mlen_reg + LEN_W'(1);
                        end
                        else
                        begin
                            ovf_next = 1'b1;
                        end
                        if (req.last_char)
                        begin
                            if (ovf_next || klen_reg == '0)
                            begin
                                res_status_next = ST_BADKEY;
                                res_slot_next   = '0;
                                state_next      = S_EMIT;
                            end
                            else
                            begin
                                div_start  = 1'b1;
                                state_next = S_DIVQ;
                            end
                        end
                    end
                end
            end
            S_DIVQ:
            begin
                if (div_stat.done)
                begin
                    hq_next    = SUM_W'(recip_prod >> HASH_SHIFT);
                    state_next = S_DIVM;
                end
            end
            S_DIVM:
            begin
                s_next     = home;
                base_next  = BASE_W'(int'(home) * MAX_CHARS);
                n_next     = '0;
                state_next = S_PROBE;
            end
            S_PROBE:
            begin
                if (n_reg == NCNT_W'(SLOTS))
                begin
                    res_status_next = (cmd_reg == CMD_INSERT) ? ST_FULL : ST_MISS;
                    res_slot_next   = '0;
                    state_next      = S_EMIT;
                end
                else if (cmd_reg == CMD_INSERT)
                begin
                    if (!used_reg[s_reg])
                    begin
                        used_next[s_reg] = 1'b1;
                        slen_we          = 1'b1;
                        idx_next         = '0;
                        state_next       = S_CP_RD;
                    end
                    else
                    begin
                        advance = 1'b1;
                    end
                end
                else if (used_reg[s_reg] && slot_klen_reg[s_reg] == klen_reg)
                begin
                    idx_next   = '0;
                    state_next = S_KCMP_RD;
                end
                else
                begin
                    advance = 1'b1;
                end
            end
            S_KCMP_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_KCMP_CHK;
            end
            S_KCMP_CHK:
            begin
                if (key_rd_reg != ik_rd_reg)
                begin
                    advance    = 1'b1;
                    state_next = S_PROBE;
                end
                else if (idx_ext + LEN_W'(1) == klen_reg)
                begin
                    idx_next      = '0;
                    res_slot_next = SLOTO_W'(s_reg);
                    if (cmd_reg == CMD_REMOVE)
                    begin
                        used_next[s_reg] = 1'b0;
                        res_status_next  = ST_REMOVED;
                        state_next       = S_EMIT;
                    end
                    else if (slot_mlen_reg[s_reg] == '0)
                    begin
                        res_status_next = ST_FOUND;
                        state_next      = S_EMIT;
                    end
                    else
                    begin
                        state_next = S_FIND_RD;
                    end
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_KCMP_RD;
                end
            end
            S_CP_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_CP_WR;
            end
            S_CP_WR:
            begin
                st_we = 1'b1;
                if (idx_reg == IDX_W'(MAX_CHARS - 1))
                begin
                    res_status_next = ST_STORED;
                    res_slot_next   = SLOTO_W'(s_reg);
                    state_next      = S_EMIT;
                end
                else
                begin
                    idx_next   = idx_reg + IDX_W'(1);
                    state_next = S_CP_RD;
                end
            end
            S_FIND_RD:
            begin
                rd_en      = 1'b1;
                state_next = S_FIND_EMIT;
            end
            S_FIND_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = ST_FOUND;
                    out_slot_next   = SLOTO_W'(s_reg);
                    out_char_next   = mean_rd_reg;
                    out_last_next   = (idx_ext + LEN_W'(1) == slot_mlen_reg[s_reg]);
                    if (out_last_next)
                    begin
                        klen_next  = '0;
                        sum_next   = '0;
                        mlen_next  = '0;
                        ovf_next   = 1'b0;
                        kdone_next = 1'b0;
                        state_next = S_IDLE;
                    end
                    else
                    begin
                        idx_next   = idx_reg + IDX_W'(1);
                        state_next = S_FIND_RD;
                    end
                end
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_status_next = res_status_reg;
                    out_slot_next   = res_slot_reg;
                    out_char_next   = '0;
                    out_last_next   = 1'b1;
                    klen_next       = '0;
                    sum_next        = '0;
                    mlen_next       = '0;
                    ovf_next        = 1'b0;
                    kdone_next      = 1'b0;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase

        if (advance)
        begin
            n_next = n_reg + NCNT_W'(1);
            if (s_reg == SLOT_W'(SLOTS - 1))
            begin
                s_next    = '0;
                base_next = '0;
            end
            else
            begin
                s_next    = s_reg + SLOT_W'(1);
                base_next = base_reg + BASE_W'(MAX_CHARS);
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            klen_reg      <= '0;
            sum_reg       <= '0;
            mlen_reg      <= '0;
            ovf_reg       <= 1'b0;
            kdone_reg     <= 1'b0;
            used_reg      <= '0;
            out_valid_reg <= 1'b0;
            n_reg         <= '0;
            s_reg         <= '0;
            base_reg      <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            klen_reg      <= klen_next;
            sum_reg       <= sum_next;
            mlen_reg      <= mlen_next;
            ovf_reg       <= ovf_next;
            kdone_reg     <= kdone_next;
            used_reg      <= used_next;
            out_valid_reg <= out_valid_next;
            n_reg         <= n_next;
            s_reg         <= s_next;
            base_reg      <= base_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg        <= cmd_next;
        idx_reg        <= idx_next;
        hq_reg         <= hq_next;
        res_status_reg <= res_status_next;
        res_slot_reg   <= res_slot_next;
        out_status_reg <= out_status_next;
        out_slot_reg   <= out_slot_next;
        out_char_reg   <= out_char_next;
        out_last_reg   <= out_last_next;
    end

    // incoming key and meaning buffers
    always_ff @(posedge clk)
    begin
        if (ik_we)
        begin
            ik_mem[in_addr] <= req.char_code;
        end
        if (im_we)
        begin
            im_mem[in_addr] <= req.char_code;
        end
        if (rd_en)
        begin
            ik_rd_reg <= ik_mem[idx_reg];
            im_rd_reg <= im_mem[idx_reg];
        end
    end

    // slot stores
    always_ff @(posedge clk)
    begin
        if (st_we && idx_ext < klen_reg)
        begin
            key_mem[mem_addr] <= ik_rd_reg;
        end
        if (st_we && idx_ext < mlen_reg)
        begin
            mean_mem[mem_addr] <= im_rd_reg;
        end
        if (rd_en)
        begin
            key_rd_reg  <= key_mem[mem_addr];
            mean_rd_reg <= mean_mem[mem_addr];
        end
        if (slen_we)
        begin
            slot_klen_reg[s_reg] <= klen_reg;
            slot_mlen_reg[s_reg] <= mlen_reg;
        end
    end

    a_div_in_div_states: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.busy |-> (state_reg == S_DIVQ || state_reg == S_DIVM))
        else $error("divider busy outside division states");

    a_probe_count: assert property (@(posedge clk) disable iff (!rst_n)
        n_reg <= NCNT_W'(SLOTS) && s_reg < SLOT_W'(SLOTS))
        else $error("probe counter or slot out of range");

    a_base_tracks_slot: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_PROBE |-> base_reg == BASE_W'(int'(s_reg) * MAX_CHARS))
        else $error("store base out of step with probe slot");

    a_no_load_over_pending: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && !rsp.ready) |=> $stable(out_char_reg) && $stable(out_status_reg))
        else $error("result register overwritten while held");

    a_insert_claims_slot: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_PROBE && state_next == S_CP_RD) |=> used_reg[s_reg])
        else $error("insert copy started without claiming slot");

endmodule

### test/word_dictionary_hash_probe_test.sv
// Self-checking bench for the word dictionary hash probe: streams insert, find and
// remove commands, predicts every result and compares every field of each transfer.
// Depends on wdh_pkg, wdh_if and the word_dictionary_hash_probe design files.
`timescale 1ns / 1ps

module word_dictionary_hash_probe_test;
    import wdh_pkg::*;

    typedef struct packed {
        logic [STAT_W-1:0]  status;
        logic [SLOTO_W-1:0] slot;
        logic [CHR_W-1:0]   meaning_char;
        logic               last;
    } answer_t;

    typedef byte unsigned word_t[$];

    logic clk = 1'b0;
    logic rst_n = 1'b0;

    wdh_in_if  req();
    wdh_out_if rsp();

    word_dictionary_hash_probe u_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req.sink),
        .rsp   (rsp.source)
    );

    bit               tab_used[SLOTS];
    byte unsigned     tab_key[SLOTS][$];
    byte unsigned     tab_mean[SLOTS][$];
    byte unsigned     in_key[$];
    byte unsigned     in_mean[$];
    int unsigned      in_sum;
    bit               in_long;
    bit               in_keydone;

    answer_t          answers_due[$];
    int               send_idle_pct;
    int               recv_idle_pct;
    int               hold_recv;
    int               mismatches;
    int               answers_seen;
    int               items_sent;
    longint           cycles;

    initial
    begin
        forever #4 clk = ~clk;
    end

    initial
    begin
        req.valid     = 1'b0;
        req.command   = CMD_INSERT;
        req.part      = 1'b0;
        req.char_code = 8'd0;
        req.last_char = 1'b0;
        rsp.ready     = 1'b0;
    end

    function automatic void clear_incoming();
        in_key.delete();
        in_mean.delete();
        in_sum     = 0;
        in_long    = 1'b0;
        in_keydone = 1'b0;
    endfunction

    function automatic void push_answer(status_t st, int s, byte unsigned ch, bit lst);
        answer_t a;
        a.status       = st;
        a.slot         = s[SLOTO_W-1:0];
        a.meaning_char = ch;
        a.last         = lst;
        answers_due.push_back(a);
    endfunction

    function automatic bit key_equal(int s);
        if (!tab_used[s] || tab_key[s].size() != in_key.size())
            return 1'b0;
        foreach (in_key[i])
            if (tab_key[s][i] != in_key[i])
                return 1'b0;
        return 1'b1;
    endfunction

    function automatic void predict_lookup(logic [CMD_W-1:0] cmd);
        int h;
        int s;
        h = (in_sum / in_key.size()) % SLOTS;
        for (int n = 0; n < SLOTS; n++)
        begin
            s = (h + n) % SLOTS;
            if (key_equal(s))
            begin
                if (cmd == CMD_REMOVE)
                begin
                    tab_used[s] = 1'b0;
                    push_answer(ST_REMOVED, s, 8'd0, 1'b1);
                end
                else if (tab_mean[s].size() == 0)
                    push_answer(ST_FOUND, s, 8'd0, 1'b1);
                else
                    foreach (tab_mean[s][i])
                        push_answer(ST_FOUND, s, tab_mean[s][i],
                                    i == tab_mean[s].size() - 1);
                return;
            end
        end
        push_answer(ST_MISS, 0, 8'd0, 1'b1);
    endfunction

    function automatic void predict_insert();
        int h;
        int s;
        h = (in_sum / in_key.size()) % SLOTS;
        for (int n = 0; n < SLOTS; n++)
        begin
            s = (h + n) % SLOTS;
            if (!tab_used[s])
            begin
                tab_used[s] = 1'b1;
                tab_key[s]  = in_key;
                tab_mean[s] = in_mean;
                push_answer(ST_STORED, s, 8'd0, 1'b1);
                return;
            end
        end
        push_answer(ST_FULL, 0, 8'd0, 1'b1);
    endfunction

    function automatic void predict_dictionary(logic [CMD_W-1:0] cmd, bit prt,
                                               byte unsigned ch, bit lst);
        if (!prt)
        begin
            if (in_keydone)
                clear_incoming();
            if (in_key.size() < MAX_CHARS)
            begin
                in_key.push_back(ch);
                in_sum += ch;
            end
            else
                in_long = 1'b1;
            if (!lst)
                return;
            in_keydone = 1'b1;
            if (cmd == CMD_INSERT)
                return;
            if (cmd != CMD_NONE)
            begin
                if (in_long)
                    push_answer(ST_BADKEY, 0, 8'd0, 1'b1);
                else
                    predict_lookup(cmd);
            end
            clear_incoming();
            return;
        end
        if (cmd != CMD_INSERT)
            return;
        if (in_mean.size() < MAX_CHARS)
            in_mean.push_back(ch);
        else
            in_long = 1'b1;
        if (!lst)
            return;
        if (in_long || in_key.size() == 0)
            push_answer(ST_BADKEY, 0, 8'd0, 1'b1);
        else
            predict_insert();
        clear_incoming();
    endfunction

    task automatic send_char(logic [CMD_W-1:0] cmd, bit prt, byte unsigned ch, bit lst);
        while (send_idle_pct > 0 && $urandom_range(99) < send_idle_pct)
        begin
            req.valid <= 1'b0;
            @(posedge clk);
        end
        req.valid     <= 1'b1;
        req.command   <= cmd;
        req.part      <= prt;
        req.char_code <= ch;
        req.last_char <= lst;
        do
            @(posedge clk);
        while (!req.ready);
        predict_dictionary(cmd, prt, ch, lst);
        items_sent++;
    endtask

    task automatic send_part(logic [CMD_W-1:0] cmd, bit prt, word_t w);
        foreach (w[i])
            send_char(cmd, prt, w[i], i == w.size() - 1);
    endtask

    task automatic send_insert(word_t k, word_t m);
        send_part(CMD_INSERT, 1'b0, k);
        send_part(CMD_INSERT, 1'b1, m);
    endtask

    function automatic word_t random_word(int lo, int hi);
        word_t w;
        int n;
        n = $urandom_range(hi, lo);
        for (int i = 0; i < n; i++)
            w.push_back(byte'($urandom_range(255, 1)));
        return w;
    endfunction

    function automatic word_t short_word(int n);
        word_t w;
        for (int i = 0; i < n; i++)
            w.push_back(byte'($urandom_range(8'h63, 8'h61)));
        return w;
    endfunction

    task automatic drain();
        req.valid <= 1'b0;
        while (answers_due.size() != 0)
            @(posedge clk);
        repeat (40) @(posedge clk);
    endtask

    always @(posedge clk)
    begin
        answer_t got;
        answer_t want;
        if (rst_n && rsp.valid && rsp.ready)
        begin
            answers_seen++;
            got.status       = rsp.status;
            got.slot         = rsp.slot;
            got.meaning_char = rsp.meaning_char;
            got.last         = rsp.last;
            if (answers_due.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                    $display("unexpected result %h", got);
            end
            else
            begin
                want = answers_due.pop_front();
                if (got !== want)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display({"mismatch: expected st %0d slot %0d ch %h last %b,",
                                  " got st %0d slot %0d ch %h last %b"},
                                 want.status, want.slot, want.meaning_char, want.last,
                                 got.status, got.slot, got.meaning_char, got.last);
                end
            end
        end
        if (hold_recv > 0)
        begin
            hold_recv <= hold_recv - 1;
            rsp.ready <= 1'b0;
        end
        else
            rsp.ready <= rst_n && !(recv_idle_pct > 0 && $urandom_range(99) < recv_idle_pct);
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles > 400000)
        begin
            $display("CHECK FAILED");
            $finish;
        end
    end

    task automatic test_directed();
        word_t k;
        word_t m;
        word_t big;
        send_insert('{8'h01}, '{8'hFF});
        send_insert('{8'hFF, 8'h80}, '{8'h41, 8'h42, 8'h43});
        send_part(CMD_FIND, 1'b0, '{8'hFF, 8'h80});
        send_part(CMD_FIND, 1'b0, '{8'h01});
        send_part(CMD_FIND, 1'b0, '{8'h7F});
        send_part(CMD_REMOVE, 1'b0, '{8'h01});
        send_part(CMD_REMOVE, 1'b0, '{8'h01});
        send_char(CMD_INSERT, 1'b1, 8'h55, 1'b1);
        send_char(CMD_NONE, 1'b0, 8'hAA, 1'b1);
        send_char(CMD_FIND, 1'b1, 8'h10, 1'b1);
        big = random_word(30, 30);
        send_part(CMD_FIND, 1'b0, big);
        drain();
        k = short_word(2);
        m = random_word(29, 31);
        send_insert(k, m);
        send_part(CMD_FIND, 1'b0, k);
        k = short_word(3);
        send_part(CMD_INSERT, 1'b0, k);
        send_part(CMD_INSERT, 1'b0, '{8'h02});
        send_part(CMD_INSERT, 1'b1, '{8'h20, 8'h21});
        send_part(CMD_FIND, 1'b0, '{8'h02});
        drain();
    endtask

    task automatic test_fill_table();
        word_t k;
        k = short_word(2);
        send_insert(k, '{8'h7A});
        for (int i = 0; i < SLOTS; i++)
            send_insert('{8'h61}, '{byte'(i + 1)});
        send_part(CMD_FIND, 1'b0, k);
        send_part(CMD_REMOVE, 1'b0, k);
        drain();
        for (int i = 0; i < SLOTS; i++)
            send_part(CMD_REMOVE, 1'b0, '{8'h61});
        drain();
    endtask

    task automatic test_backpressure();
        hold_recv = 600;
        for (int i = 0; i < 3; i++)
            send_insert(short_word(2), short_word(2));
        for (int i = 0; i < 2; i++)
            send_part(CMD_FIND, 1'b0, short_word(2));
        drain();
    endtask

    task automatic random_phase(int n, int sidle, int ridle);
        int pick;
        send_idle_pct = sidle;
        recv_idle_pct = ridle;
        for (int i = 0; i < n; i++)
        begin
            pick = $urandom_range(99);
            if (pick < 40)
                send_insert(short_word($urandom_range(3, 1)),
                            $urandom_range(9) == 0 ? random_word(1, 31) : short_word(3));
            else if (pick < 65)
                send_part(CMD_FIND, 1'b0, short_word($urandom_range(3, 1)));
            else if (pick < 85)
                send_part(CMD_REMOVE, 1'b0, short_word($urandom_range(3, 1)));
            else
                send_char(CMD_W'($urandom_range(3)), 1'($urandom_range(1)),
                          byte'($urandom_range(255, 1)), 1'($urandom_range(1)));
        end
        drain();
    endtask

    initial
    begin
        send_idle_pct = 0;
        recv_idle_pct = 0;
        hold_recv     = 0;
        mismatches    = 0;
        answers_seen  = 0;
        items_sent    = 0;
        cycles        = 0;
        for (int s = 0; s < SLOTS; s++)
            tab_used[s] = 1'b0;
        clear_incoming();
        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_directed();
        test_fill_table();
        test_backpressure();
        random_phase(3, 35, 55);
        random_phase(3, 55, 35);
        random_phase(3, 0, 0);
        $display("covered insert, find, remove, full table, bad keys, stalls:");
        $display("  %0d items sent, %0d results checked", items_sent, answers_seen);
        if (mismatches == 0 && answers_due.size() == 0)
            $display("CHECK OK");
        else
            $display("CHECK FAILED");
        $finish;
    end

endmodule

### word_dictionary_hash_probe.f
design/wdh_pkg.sv
design/wdh_if.sv
design/wdh_div.sv
design/word_dictionary_hash_probe.sv
test/word_dictionary_hash_probe_test.sv
